>>> rtl/ptc_pkg.sv
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int ALPHABET_SIZE = 62;
  localparam int CODE_W = 6;

  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_DIGIT_0 = 8'd48;
  localparam logic [7:0] CH_DIGIT_9 = 8'd57;
  localparam logic [7:0] UPPER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_WORD   = 2'd1;
  localparam logic [1:0] REQ_PREFIX = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SYMBOL = 2'd1;
  localparam logic [1:0] ST_POOL_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ALLOC,
    S_UPDATE,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] symbol;
    logic       last_symbol;
  } req_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic clear;
  } node_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } sym_t;

  function automatic sym_t sym_decode(input logic [7:0] ch);
    sym_t s;
    s.valid = 1'b1;
    s.code = '0;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      s.code = CODE_W'(ch - CH_LOWER_A);
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      s.code = CODE_W'(ch - CH_UPPER_A + UPPER_BASE);
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      s.code = CODE_W'(ch - CH_DIGIT_0 + DIGIT_BASE);
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> rtl/prefix_trie_counter.sv
`timescale 1ns / 1ps

// Prefix trie counter over the 62 symbols a-z, A-Z and 0-9.
// A word on req is taken at a rising edge where start is high and busy is low. Strings
// arrive one character per word; the word with last_symbol set closes the string and
// produces exactly one word on result, marked by done for one cycle. A clear request
// produces nothing. Results cannot be held off by the receiver.
// A character that walks the trie passes through S_LOOKUP and, when it updates or
// allocates a child or ends a query on a present child, then S_UPDATE, S_ALLOC or
// S_FETCH: the current node row and its child pointer are read first, then a child
// row is read or allocated and its counters written back in the node memory. A
// character skipped after an error or a missing path is handled in S_IDLE without busy.
// The result appears the cycle after the character's last cycle. Node storage is
// one row memory (child mask and counters) and one child pointer memory, each with a
// registered read port; busy keeps accesses of different characters apart.
// Reset and clear empty the pool at once (the root row's child mask is held in flops),
// so no clearing pass is needed. Characters outside the alphabet report status 1 and a
// full pool reports status 2, in both cases with count 0 and a partial insert kept.

module prefix_trie_counter #(
  parameter int MAX_NODES = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptc_pkg::req_t     req,
  output logic              done,
  output ptc_pkg::result_t  result
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NFREE_W = $clog2(MAX_NODES + 1);
  localparam int SLOTS = MAX_NODES * ptc_pkg::ALPHABET_SIZE;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int MASK_W = ptc_pkg::ALPHABET_SIZE;
  localparam int ROW_W = MASK_W + 2 * COUNT_BITS;
  localparam int CODE_W = ptc_pkg::CODE_W;

  ptc_pkg::state_t state, state_next;

  logic [NODE_W-1:0]  cursor, cursor_next;
  logic [NFREE_W-1:0] nfree, nfree_next;
  logic               missed, missed_next;
  logic [1:0]         pending, pending_next;

  logic [1:0]         req_q;
  logic [CODE_W-1:0]  code_q;
  logic               last_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [NODE_W-1:0]  child_q, child_next;
  logic               latch;

  logic               accept;
  ptc_pkg::sym_t      sym;
  logic [SLOT_W-1:0]  slot_calc;

  logic [NODE_W-1:0]  ptr_mem [SLOTS];
  logic [NODE_W-1:0]  ptr_q;
  logic               ptr_we;

  ptc_pkg::node_ctl_t node_ctl;
  logic [NODE_W-1:0]  node_rd_addr;
  logic [NODE_W-1:0]  node_wr_addr;
  logic [ROW_W-1:0]   node_wr_data;
  logic [ROW_W-1:0]   node_q;

  logic [MASK_W-1:0]     row_mask;
  logic [COUNT_BITS-1:0] row_pass;
  logic [COUNT_BITS-1:0] row_end;
  logic [COUNT_BITS-1:0] pass_inc;
  logic [COUNT_BITS-1:0] end_new;
  logic                  present;
  logic                  pool_full;

  logic        emit;
  logic [15:0] emit_value;
  logic [1:0]  emit_status;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] clamp16(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  assign busy = (state != ptc_pkg::S_IDLE);
  assign accept = start && !busy;
  assign sym = ptc_pkg::sym_decode(req.symbol);
  assign slot_calc = SLOT_W'({cursor, 6'd0}) - SLOT_W'({cursor, 1'b0}) + SLOT_W'(sym.code);

  assign row_mask = node_q[ROW_W-1 -: MASK_W];
  assign row_pass = node_q[2*COUNT_BITS-1 -: COUNT_BITS];
  assign row_end = node_q[COUNT_BITS-1:0];
  assign pass_inc = sat_inc(row_pass);
  assign end_new = last_q ? sat_inc(row_end) : row_end;
  assign present = row_mask[code_q];
  assign pool_full = (nfree >= NFREE_W'(MAX_NODES));

  ptc_node_mem #(
    .DEPTH (MAX_NODES),
    .NODE_W(NODE_W),
    .ROW_W (ROW_W)
  ) u_node_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (node_ctl),
    .rd_addr(node_rd_addr),
    .rd_data(node_q),
    .wr_addr(node_wr_addr),
    .wr_data(node_wr_data)
  );

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      ptr_mem[slot_q] <= child_next;
    end
    ptr_q <= ptr_mem[slot_calc];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptc_pkg::S_IDLE: begin
        if (accept && req.req_type != ptc_pkg::REQ_CLEAR && pending == ptc_pkg::ST_OK &&
            !missed && sym.valid) begin
          state_next = ptc_pkg::S_LOOKUP;
        end
      end
      ptc_pkg::S_LOOKUP: begin
        if (req_q != ptc_pkg::REQ_INSERT) begin
          state_next = (present && last_q) ? ptc_pkg::S_FETCH : ptc_pkg::S_IDLE;
        end else if (present) begin
          state_next = ptc_pkg::S_UPDATE;
        end else begin
          state_next = pool_full ? ptc_pkg::S_IDLE : ptc_pkg::S_ALLOC;
        end
      end
      ptc_pkg::S_ALLOC:  state_next = ptc_pkg::S_IDLE;
      ptc_pkg::S_UPDATE: state_next = ptc_pkg::S_IDLE;
      ptc_pkg::S_FETCH:  state_next = ptc_pkg::S_IDLE;
      default:           state_next = ptc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cursor_next = cursor;
    nfree_next = nfree;
    missed_next = missed;
    pending_next = pending;
    child_next = child_q;
    latch = 1'b0;
    emit = 1'b0;
    emit_value = '0;
    emit_status = ptc_pkg::ST_OK;
    ptr_we = 1'b0;
    node_ctl = '0;
    node_rd_addr = cursor;
    node_wr_addr = cursor;
    node_wr_data = node_q;
    unique case (state)
      ptc_pkg::S_IDLE: begin
        if (accept) begin
          if (req.req_type == ptc_pkg::REQ_CLEAR) begin
            node_ctl.clear = 1'b1;
            nfree_next = NFREE_W'(1);
            cursor_next = '0;
            missed_next = 1'b0;
            pending_next = ptc_pkg::ST_OK;
          end else if (pending != ptc_pkg::ST_OK || missed) begin
            if (req.last_symbol) begin
              emit = 1'b1;
              emit_status = pending;
            end
          end else if (!sym.valid) begin
            if (req.last_symbol) begin
              emit = 1'b1;
              emit_status = ptc_pkg::ST_BAD_SYMBOL;
            end else begin
              pending_next = ptc_pkg::ST_BAD_SYMBOL;
            end
          end else begin
            latch = 1'b1;
          end
        end
      end
      ptc_pkg::S_LOOKUP: begin
        node_rd_addr = ptr_q;
        if (req_q != ptc_pkg::REQ_INSERT) begin
          if (present) begin
            cursor_next = ptr_q;
          end else if (last_q) begin
            emit = 1'b1;
          end else begin
            missed_next = 1'b1;
          end
        end else if (present) begin
          child_next = ptr_q;
        end else if (pool_full) begin
          if (last_q) begin
            emit = 1'b1;
            emit_status = ptc_pkg::ST_POOL_FULL;
          end else begin
            pending_next = ptc_pkg::ST_POOL_FULL;
          end
        end else begin
          child_next = nfree[NODE_W-1:0];
          nfree_next = nfree + 1'b1;
          ptr_we = 1'b1;
          node_ctl.wr_en = 1'b1;
          node_wr_data = {row_mask | (MASK_W'(1) << code_q), row_pass, row_end};
        end
      end
      ptc_pkg::S_ALLOC: begin
        node_ctl.wr_en = 1'b1;
        node_wr_addr = child_q;
        node_wr_data = {MASK_W'(0), COUNT_BITS'(1), COUNT_BITS'(last_q)};
        cursor_next = child_q;
        if (last_q) begin
          emit = 1'b1;
          emit_value = 16'd1;
        end
      end
      ptc_pkg::S_UPDATE: begin
        node_ctl.wr_en = 1'b1;
        node_wr_addr = child_q;
        node_wr_data = {row_mask, pass_inc, end_new};
        cursor_next = child_q;
        if (last_q) begin
          emit = 1'b1;
          emit_value = clamp16(end_new);
        end
      end
      ptc_pkg::S_FETCH: begin
        emit = 1'b1;
        emit_value = (req_q == ptc_pkg::REQ_PREFIX) ? clamp16(row_pass) : clamp16(row_end);
      end
      default: begin
      end
    endcase
    if (emit) begin
      cursor_next = '0;
      missed_next = 1'b0;
      pending_next = ptc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptc_pkg::S_IDLE;
      cursor <= '0;
      nfree <= NFREE_W'(1);
      missed <= 1'b0;
      pending <= ptc_pkg::ST_OK;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cursor <= cursor_next;
      nfree <= nfree_next;
      missed <= missed_next;
      pending <= pending_next;
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      req_q <= req.req_type;
      code_q <= sym.code;
      last_q <= req.last_symbol;
      slot_q <= slot_calc;
    end
    child_q <= child_next;
    if (emit) begin
      result.count_value <= emit_value;
      result.status <= emit_status;
    end
  end

`ifndef NO_ASSERTIONS
  a_nfree_bound: assert property (@(posedge clk) disable iff (rst)
    nfree <= NFREE_W'(MAX_NODES) && nfree != '0)
    else $error("free node index out of range");

  a_cursor_allocated: assert property (@(posedge clk) disable iff (rst)
    NFREE_W'(cursor) < nfree)
    else $error("cursor points at an unallocated node");

  a_error_zero_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ptc_pkg::ST_OK |-> result.count_value == 16'd0)
    else $error("error result carries a nonzero count");

  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ##[1:2] !busy)
    else $error("character took more than three cycles");

  a_nfree_step: assert property (@(posedge clk) disable iff (rst)
    nfree != $past(nfree) |-> nfree == $past(nfree) + 1'b1 || nfree == NFREE_W'(1))
    else $error("free node index moved by more than one");
`endif

endmodule

>>> rtl/ptc_node_mem.sv
`timescale 1ns / 1ps

module ptc_node_mem #(
  parameter int DEPTH = 1024,
  parameter int NODE_W = 10,
  parameter int ROW_W = 94
) (
  input  logic              clk,
  input  logic              rst,
  input  ptc_pkg::node_ctl_t ctl,
  input  logic [NODE_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic [NODE_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  localparam int MASK_W = ptc_pkg::ALPHABET_SIZE;
  localparam int CNT_W = ROW_W - MASK_W;

  // The root row's child mask lives in flops so that reset and clear empty it at once.
  logic [ROW_W-1:0]  mem [DEPTH];
  logic [ROW_W-1:0]  rd_q;
  logic              rd_root;
  logic [MASK_W-1:0] root_mask;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
    rd_root <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      root_mask <= '0;
    end else if (ctl.wr_en && wr_addr == '0) begin
      root_mask <= wr_data[ROW_W-1 -: MASK_W];
    end
  end

  assign rd_data = rd_root ? {root_mask, rd_q[CNT_W-1:0]} : rd_q;

endmodule
